// ----- rtl/sca_pkg.sv -----
// Package for the stack calculator: field widths, command, operation and status codes,
// and the sequencer state type.
// It has no dependencies. The interfaces and the top level use it.
package sca_pkg;

   localparam int WORD_W              = 32;
   localparam int CMD_W               = 2;
   localparam int OP_W                = 3;
   localparam int STATUS_W            = 3;
   localparam int DEPTH_W             = 5;
   localparam int STACK_DEPTH_DEFAULT = 16;

   // One divider or multiplier step for each bit of the word.
   localparam int                ITER_W    = $clog2(WORD_W);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(WORD_W - 1);

   localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_OPERATE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

   localparam logic [OP_W-1:0] OP_ADD = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV = 3'd3;
   localparam logic [OP_W-1:0] OP_REM = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SINGLE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DIVZERO = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_ITER,
      ST_COMMIT,
      ST_FINISH
   } sca_state_type;

endpackage

// ----- rtl/sca_if.sv -----
// Valid/ready channels of the stack calculator: the command channel and the result channel.
// Depends on sca_pkg for the field widths.
interface sca_req_if;
   logic                               valid;
   logic                               ready;
   logic        [sca_pkg::CMD_W-1:0]   command;
   logic signed [sca_pkg::WORD_W-1:0]  value;
   logic        [sca_pkg::OP_W-1:0]    operation;

   modport source (output valid, command, value, operation, input ready);
   modport sink   (input valid, command, value, operation, output ready);
endinterface

interface sca_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [sca_pkg::STATUS_W-1:0] status;
   logic signed [sca_pkg::WORD_W-1:0]   result_value;
   logic        [sca_pkg::DEPTH_W-1:0]  depth;

   modport source (output valid, status, result_value, depth, input ready);
   modport sink   (input valid, status, result_value, depth, output ready);
endinterface

// ----- rtl/stack_calculator_alu_top.sv -----
// Stack calculator (reverse Polish) over signed 32-bit words.
// Depends on sca_pkg and on the channel interfaces in sca_if.sv.
//
// Commands arrive on req_ch (push a value, operate on the top two words, peek the top)
// and every command gives exactly one item on rsp_ch: a status, a result value and
// the stack depth after the command. Both channels use valid/ready, and an item moves
// at a clock edge where both are high.
// The block takes one command at a time. req_ch.ready is high only while the sequencer
// is idle. Push, peek, errors, add and subtract pass from decode through at most read and
// commit to finish. Multiply, divide and remainder add a bit-serial loop between read
// and commit, with one step of the shared 33-bit adder for each of the 32 bits.
// The stack is a register array with one write port and two registered read ports.
// The array is not cleared. Only the count is reset.
// A finished item waits in an output register. While rsp_ch is stalled, the block goes
// back to idle and accepts the next command. That command's result then waits until
// the output register is free.
// A synchronous reset empties the stack and drops any pending item.
module stack_calculator_alu_top #(
   parameter int STACK_DEPTH = sca_pkg::STACK_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   sca_req_if.sink   req_ch,
   sca_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int W  = sca_pkg::WORD_W;

   sca_pkg::sca_state_type state_ff, state_in;

   logic [sca_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [W-1:0]                 value_ff, value_in;
   logic [sca_pkg::OP_W-1:0]     op_ff, op_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [W-1:0]                 acc_ff, acc_in;
   logic [W-1:0]                 mq_ff, mq_in;
   logic [W-1:0]                 div_ff, div_in;
   logic [sca_pkg::ITER_W-1:0]   iter_ff, iter_in;
   logic                         sign_a_ff, sign_a_in;
   logic                         sign_b_ff, sign_b_in;
   logic [sca_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [W-1:0]                 res_value_ff, res_value_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sca_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [W-1:0]                 rsp_value_ff, rsp_value_in;
   logic [sca_pkg::DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;

   // Stack memory with registered reads of the top and the next word.
   logic [W-1:0]  stack_mem [STACK_DEPTH];
   logic [W-1:0]  rd_a_ff, rd_b_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [W-1:0]  mem_wdata;
   logic [CW-1:0] top_idx, next_idx;
   logic [CW+4:0] count_ext;

   // Shared adder/subtractor.
   logic [W:0] add_x, add_y, add_sum;
   logic       add_sub;

   logic [W-1:0] mag_a, mag_b, quot_neg, rem_neg, commit_value;
   logic         is_divide;

   assign top_idx   = count_ff - CW'(1);
   assign next_idx  = count_ff - CW'(2);
   assign count_ext = {5'b0, count_ff};
   assign is_divide = op_ff inside {sca_pkg::OP_DIV, sca_pkg::OP_REM};

   assign mag_a    = rd_a_ff[W-1] ? (~rd_a_ff + W'(1)) : rd_a_ff;
   assign mag_b    = rd_b_ff[W-1] ? (~rd_b_ff + W'(1)) : rd_b_ff;
   assign quot_neg = ~mq_ff + W'(1);
   assign rem_neg  = ~acc_ff + W'(1);

   always_comb begin
      case (op_ff)
         sca_pkg::OP_DIV: commit_value = (sign_a_ff != sign_b_ff) ? quot_neg : mq_ff;
         sca_pkg::OP_REM: commit_value = sign_a_ff ? rem_neg : acc_ff;
         default:         commit_value = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == sca_pkg::ST_DECODE) begin
         rd_a_ff <= stack_mem[top_idx[AW-1:0]];
         rd_b_ff <= stack_mem[next_idx[AW-1:0]];
      end
   end

   // Operand selection for the shared adder.
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      case (state_ff)
         sca_pkg::ST_READ: begin
            add_x   = {rd_a_ff[W-1], rd_a_ff};
            add_y   = {rd_b_ff[W-1], rd_b_ff};
            add_sub = (op_ff == sca_pkg::OP_SUB);
         end
         sca_pkg::ST_ITER: begin
            if (op_ff == sca_pkg::OP_MUL) begin
               // Shift-and-add from the top bit of the multiplier down.
               add_x = {1'b0, acc_ff[W-2:0], 1'b0};
               add_y = mq_ff[W-1] ? {1'b0, div_ff} : '0;
            end else begin
               // Restoring division: the partial remainder stays below the divisor.
               add_x   = {1'b0, acc_ff[W-2:0], mq_ff[W-1]};
               add_y   = {1'b0, div_ff};
               add_sub = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign add_sum = add_x + (add_sub ? ~add_y : add_y) + (W + 1)'(add_sub);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      op_in         = op_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      mq_in         = mq_ff;
      div_in        = div_ff;
      iter_in       = iter_ff;
      sign_a_in     = sign_a_ff;
      sign_b_in     = sign_b_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_depth_in  = rsp_depth_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;

      case (state_ff)
         sca_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               value_in = req_ch.value;
               op_in    = req_ch.operation;
               state_in = sca_pkg::ST_DECODE;
            end
         end
         sca_pkg::ST_DECODE: begin
            res_status_in = sca_pkg::STATUS_OK;
            res_value_in  = '0;
            state_in      = sca_pkg::ST_FINISH;
            case (cmd_ff)
               sca_pkg::CMD_PUSH: begin
                  if (count_ff >= CW'(STACK_DEPTH)) begin
                     res_status_in = sca_pkg::STATUS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[AW-1:0];
                     mem_wdata = value_ff;
                     count_in  = count_ff + CW'(1);
                  end
               end
               sca_pkg::CMD_OPERATE: begin
                  if (count_ff == '0) begin
                     res_status_in = sca_pkg::STATUS_EMPTY;
                  end else if (count_ff == CW'(1)) begin
                     res_status_in = sca_pkg::STATUS_SINGLE;
                  end else if (op_ff inside {[sca_pkg::OP_ADD:sca_pkg::OP_REM]}) begin
                     state_in = sca_pkg::ST_READ;
                  end
               end
               sca_pkg::CMD_PEEK: begin
                  if (count_ff == '0) begin
                     res_status_in = sca_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = sca_pkg::ST_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         sca_pkg::ST_READ: begin
            state_in = sca_pkg::ST_FINISH;
            if (cmd_ff == sca_pkg::CMD_PEEK) begin
               res_value_in = rd_a_ff;
            end else if (is_divide && rd_b_ff == '0) begin
               res_status_in = sca_pkg::STATUS_DIVZERO;
            end else begin
               case (op_ff)
                  sca_pkg::OP_ADD, sca_pkg::OP_SUB: begin
                     acc_in   = add_sum[W-1:0];
                     state_in = sca_pkg::ST_COMMIT;
                  end
                  sca_pkg::OP_MUL: begin
                     acc_in   = '0;
                     mq_in    = rd_a_ff;
                     div_in   = rd_b_ff;
                     iter_in  = '0;
                     state_in = sca_pkg::ST_ITER;
                  end
                  default: begin
                     acc_in    = '0;
                     mq_in     = mag_a;
                     div_in    = mag_b;
                     sign_a_in = rd_a_ff[W-1];
                     sign_b_in = rd_b_ff[W-1];
                     iter_in   = '0;
                     state_in  = sca_pkg::ST_ITER;
                  end
               endcase
            end
         end
         sca_pkg::ST_ITER: begin
            if (op_ff == sca_pkg::OP_MUL) begin
               acc_in = add_sum[W-1:0];
               mq_in  = {mq_ff[W-2:0], 1'b0};
            end else if (!add_sum[W]) begin
               acc_in = add_sum[W-1:0];
               mq_in  = {mq_ff[W-2:0], 1'b1};
            end else begin
               acc_in = add_x[W-1:0];
               mq_in  = {mq_ff[W-2:0], 1'b0};
            end
            iter_in = iter_ff + sca_pkg::ITER_W'(1);
            if (iter_ff == sca_pkg::ITER_LAST) begin
               state_in = sca_pkg::ST_COMMIT;
            end
         end
         sca_pkg::ST_COMMIT: begin
            // Two words are popped and the result takes the place of the lower one.
            mem_we        = 1'b1;
            mem_waddr     = next_idx[AW-1:0];
            mem_wdata     = commit_value;
            count_in      = count_ff - CW'(1);
            res_status_in = sca_pkg::STATUS_OK;
            res_value_in  = commit_value;
            state_in      = sca_pkg::ST_FINISH;
         end
         sca_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_depth_in  = count_ext[sca_pkg::DEPTH_W-1:0];
               state_in      = sca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sca_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sca_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      op_ff         <= op_in;
      acc_ff        <= acc_in;
      mq_ff         <= mq_in;
      div_ff        <= div_in;
      iter_ff       <= iter_in;
      sign_a_ff     <= sign_a_in;
      sign_b_ff     <= sign_b_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign req_ch.ready        = (state_ff == sca_pkg::ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.depth        = rsp_depth_ff;

   // The count never exceeds the capacity of the stack.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond capacity");

   // A push that fits raises the count by exactly one.
   a_push_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sca_pkg::ST_DECODE && cmd_ff == sca_pkg::CMD_PUSH
       && count_ff < CW'(STACK_DEPTH))
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the stack by one");

   // The bit loop leaves for the commit step after its last step.
   a_iter_exit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sca_pkg::ST_ITER && iter_ff == sca_pkg::ITER_LAST)
      |=> state_ff == sca_pkg::ST_COMMIT)
      else $error("iteration did not end after the last bit");

   // Any error status carries a zero result value.
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != sca_pkg::STATUS_OK) |-> rsp_value_ff == '0)
      else $error("error item with a non-zero result value");

endmodule
